### sv/urlpd_pkg.sv
// Types and constants shared by the URL percent decoder modules.
`default_nettype none
package urlpd_pkg;

  localparam int unsigned MaxOutWidth = 13;
  localparam int unsigned CountWidth  = 12;
  localparam int unsigned ResultSlots = 3;

  localparam logic [MaxOutWidth-1:0] MaxOutReset = 13'd128;
  localparam logic [MaxOutWidth-1:0] MaxOutCap   = 13'd4096;

  // Escape phase codes
  localparam logic [1:0] PH_NONE  = 2'd0;
  localparam logic [1:0] PH_PCT   = 2'd1;
  localparam logic [1:0] PH_DIGIT = 2'd2;

  localparam logic [7:0] PctChar = 8'h25;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_byte;
    logic       out_last;
    logic       truncated;
  } out_item_t;

  typedef struct packed {
    logic [1:0]            escape_phase;
    logic [7:0]            held_digit;
    logic [CountWidth-1:0] emitted_count;
    logic                  ended;
    logic                  dropped_flag;
  } dec_state_t;

  typedef struct packed {
    out_item_t [ResultSlots-1:0] items;
    logic [1:0]                  count;
  } step_res_t;

endpackage
`default_nettype wire

### sv/url_percent_decoder.sv
// Top level of the URL percent decoder.
`default_nettype none
// Decodes a percent-encoded string one byte per item, one item per cycle while
// in_stall is low. An item that yields k results (up to three) holds in_stall until
// its last result leaves the three-slot result buffer, which drains one result per
// cycle while out_stall is low; decoding is a single combinational pass from the
// escape state to the result buffer. A zero byte or in_last ends the string and
// always yields at least one result (an empty end marker if no byte). At most
// max_out-1 bytes go out per string, max_out taken in 1..4096; cfg_wr_data sets
// max_out (reset 128); the user writes it only while the block is idle (unchecked).
module url_percent_decoder (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  urlpd_pkg::in_item_t                 in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output urlpd_pkg::out_item_t                out_data,
  input  logic                                cfg_wr_en,
  input  logic [urlpd_pkg::MaxOutWidth-1:0]   cfg_wr_data
);
  import urlpd_pkg::*;

  dec_state_t             state;
  dec_state_t             state_next;
  step_res_t              res;
  logic [MaxOutWidth-1:0] max_out;
  logic                   can_load;
  logic                   accept;

  assign in_stall = !can_load;
  assign accept   = in_valid && can_load;

  urlpd_step u_step (
    .cur     (state),
    .item    (in_data),
    .max_out (max_out),
    .nxt     (state_next),
    .res     (res)
  );

  urlpd_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .load      (accept),
    .res       (res),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (accept) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_out <= MaxOutReset;
    end else if (cfg_wr_en) begin
      max_out <= cfg_wr_data;
    end
  end

endmodule
`default_nettype wire

### sv/urlpd_step.sv
// Per-item decode logic: next state and up to three result items.
`default_nettype none
module urlpd_step (
  input  urlpd_pkg::dec_state_t                  cur,
  input  urlpd_pkg::in_item_t                    item,
  input  logic [urlpd_pkg::MaxOutWidth-1:0]      max_out,
  output urlpd_pkg::dec_state_t                  nxt,
  output urlpd_pkg::step_res_t                   res
);
  import urlpd_pkg::*;

  function automatic logic is_hex(input logic [7:0] c);
    is_hex = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
             (c >= 8'h41 && c <= 8'h46);
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    hex_val = (c >= 8'h30 && c <= 8'h39) ? c[3:0] : 4'(c[3:0] + 4'd9);
  endfunction

  dec_state_t            st;
  logic [1:0]            ph;
  logic [7:0]            c;
  logic                  is_end;
  logic [7:0]            cand [4];
  logic [2:0]            k;
  logic [CountWidth-1:0] limit;
  logic [CountWidth-1:0] room;
  logic [1:0]            room_sat;
  logic [1:0]            emit_n;
  logic                  drop_now;
  logic                  drop_new;

  always_comb begin
    // Start afresh after a finished string
    st = cur;
    if (cur.ended) begin
      st = '0;
    end
    c      = item.in_byte;
    is_end = item.in_last || (c == 8'h00);
    ph     = st.escape_phase;
    for (int i = 0; i < 4; i++) begin
      cand[i] = 8'h00;
    end
    k = 3'd0;
    nxt = st;

    if (c != 8'h00) begin
      unique case (ph)
        PH_PCT: begin
          if (is_hex(c)) begin
            nxt.held_digit = c;
            ph = PH_DIGIT;
          end else if (c == PctChar) begin
            ph = PH_NONE;
            cand[k[1:0]] = PctChar;
            k = k + 3'd1;
          end else begin
            ph = PH_NONE;
            cand[k[1:0]] = PctChar;
            k = k + 3'd1;
            cand[k[1:0]] = c;
            k = k + 3'd1;
          end
        end
        PH_DIGIT: begin
          ph = PH_NONE;
          if (is_hex(c)) begin
            cand[k[1:0]] = {hex_val(st.held_digit), hex_val(c)};
            k = k + 3'd1;
          end else begin
            cand[k[1:0]] = PctChar;
            k = k + 3'd1;
            cand[k[1:0]] = st.held_digit;
            k = k + 3'd1;
            if (c == PctChar) begin
              ph = PH_PCT;
            end else begin
              cand[k[1:0]] = c;
              k = k + 3'd1;
            end
          end
        end
        default: begin
          if (c == PctChar) begin
            ph = PH_PCT;
          end else begin
            cand[k[1:0]] = c;
            k = k + 3'd1;
          end
        end
      endcase
    end

    // Flush a pending escape literally at the end
    if (is_end) begin
      if (ph == PH_PCT) begin
        cand[k[1:0]] = PctChar;
        k = k + 3'd1;
      end else if (ph == PH_DIGIT) begin
        cand[k[1:0]] = PctChar;
        k = k + 3'd1;
        cand[k[1:0]] = nxt.held_digit;
        k = k + 3'd1;
      end
      ph = PH_NONE;
      nxt.held_digit = 8'h00;
    end
    nxt.escape_phase = ph;
    nxt.ended = is_end;

    // Limit check: zero acts as one, anything above the cap acts as the cap
    if (max_out == '0) begin
      limit = '0;
    end else if (max_out > MaxOutCap) begin
      limit = CountWidth'(MaxOutCap - 13'd1);
    end else begin
      limit = CountWidth'(max_out - 13'd1);
    end
    // A limit lowered to or below the bytes already emitted leaves no room at all
    room     = (st.emitted_count >= limit) ? '0 : limit - st.emitted_count;
    room_sat = (room >= CountWidth'(3)) ? 2'd3 : room[1:0];
    emit_n   = (k > {1'b0, room_sat}) ? room_sat : k[1:0];
    drop_now = (k > {1'b0, room_sat}) && (room < CountWidth'(3));
    drop_new = st.dropped_flag || drop_now;
    nxt.dropped_flag  = drop_new;
    nxt.emitted_count = st.emitted_count + CountWidth'(emit_n);

    for (int i = 0; i < ResultSlots; i++) begin
      res.items[i].out_byte  = cand[i];
      res.items[i].has_byte  = 1'b1;
      res.items[i].out_last  = is_end && ((2'(i) + 2'd1) == emit_n);
      res.items[i].truncated = drop_new;
    end
    res.count = emit_n;
    // Empty end marker
    if (is_end && (emit_n == 2'd0)) begin
      res.items[0] = '{out_byte: 8'h00, has_byte: 1'b0, out_last: 1'b1,
                       truncated: drop_new};
      res.count = 2'd1;
    end
  end

endmodule
`default_nettype wire

### sv/urlpd_out_buf.sv
// Result buffer: holds the items of one input and drains one per cycle while out_stall is low.
`default_nettype none
module urlpd_out_buf (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  urlpd_pkg::step_res_t res,
  output logic                 can_load,
  output logic                 out_valid,
  input  logic                 out_stall,
  output urlpd_pkg::out_item_t out_data
);
  import urlpd_pkg::*;

  out_item_t [ResultSlots-1:0] items;
  logic [1:0]                  remain;
  logic [1:0]                  pos;
  logic                        pop;

  assign out_valid = (remain != 2'd0);
  assign pop       = out_valid && !out_stall;
  // Take the next item once the last pending result leaves this cycle
  assign can_load  = (remain == 2'd0) || ((remain == 2'd1) && pop);

  always_comb begin
    unique case (pos)
      2'd1:    out_data = items[1];
      2'd2:    out_data = items[2];
      default: out_data = items[0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      remain <= 2'd0;
      pos    <= 2'd0;
    end else if (load) begin
      remain <= res.count;
      pos    <= 2'd0;
    end else if (pop) begin
      remain <= remain - 2'd1;
      pos    <= pos + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      items <= res.items;
    end
  end

endmodule
`default_nettype wire
